[rtl/core/cqd_pkg.sv]
// Shared sizes, command codes and cell control type for the demotion queue.
package cqd_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = 4;   // addresses one cell
    localparam int CNT_W      = 5;   // holds 0..DEPTH

    // Command codes carried on the kind field.
    localparam logic [2:0] KIND_ENQUEUE  = 3'd0;
    localparam logic [2:0] KIND_DEQUEUE  = 3'd1;
    localparam logic [2:0] KIND_PEEK     = 3'd2;
    localparam logic [2:0] KIND_EMPTY    = 3'd3;
    localparam logic [2:0] KIND_DEMOTE_H = 3'd4;
    localparam logic [2:0] KIND_DEMOTE_N = 3'd5;

    // What every cell does at each clock.
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_LOAD   = 2'd1,   // cell at pos takes the new word
        CELL_ROTATE = 2'd2    // cells below pos take right neighbor, cell at pos takes head
    } cell_op_t;

    typedef struct packed {
        cell_op_t         op;
        logic [IDX_W-1:0] pos;
    } cell_cmd_t;

endpackage

[rtl/core/cqd_cell.sv]
// One queue cell: holds one entry in logical order, head at cell zero.
module cqd_cell (
    input  logic                           clk,
    input  logic [cqd_pkg::IDX_W-1:0]      idx,
    input  cqd_pkg::cell_cmd_t             cmd,
    input  logic [cqd_pkg::DATA_WIDTH-1:0] load_data,
    input  logic [cqd_pkg::DATA_WIDTH-1:0] right_data,
    input  logic [cqd_pkg::DATA_WIDTH-1:0] head_data,
    output logic [cqd_pkg::DATA_WIDTH-1:0] data
);

    logic [cqd_pkg::DATA_WIDTH-1:0] data_reg;
    logic [cqd_pkg::DATA_WIDTH-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        case (cmd.op)
            cqd_pkg::CELL_LOAD:
            begin
                if (idx == cmd.pos)
                    data_next = load_data;
            end
            cqd_pkg::CELL_ROTATE:
            begin
                if (idx < cmd.pos)
                    data_next = right_data;
                else if (idx == cmd.pos)
                    data_next = head_data;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    // entry contents need no reset: only held entries are ever read
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

[rtl/core/circular_queue_with_demotion.sv]
// Top level of the FIFO queue with head demotion, built as a row of shifting cells.
//
// One command per request and one response per request: a request is taken whenever
// the response register is empty or being drained, so back-to-back requests run at
// one per clock. Entries sit in a row of DEPTH cells in queue order
// (head in cell zero), so enqueue writes the cell at the current count, and dequeue
// and both demotions are a single rotate of the cells below a boundary position:
// those cells take their right neighbor's word and the boundary cell takes the old
// head. The capacity register limits how many entries may be held; writes of zero
// read as one and writes above DEPTH read as DEPTH. Lowering it below the count
// keeps every entry and refuses enqueue until the count drops. Config is always
// ready and must be written only while no request is outstanding. No clearing pass
// after reset is needed.
module circular_queue_with_demotion (
    input  logic                           clk,
    input  logic                           rst_n,

    // config write channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [4:0]                     cfg_data,

    // request channel
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [2:0]                     kind,
    input  logic [cqd_pkg::DATA_WIDTH-1:0] data_in,
    input  logic [cqd_pkg::CNT_W-1:0]      move_count,

    // response channel
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           ok,
    output logic [cqd_pkg::DATA_WIDTH-1:0] data_out,
    output logic [cqd_pkg::CNT_W-1:0]      occupancy
);

    localparam logic [cqd_pkg::CNT_W-1:0] DEPTH_C = cqd_pkg::CNT_W'(cqd_pkg::DEPTH);

    // control state
    logic [cqd_pkg::CNT_W-1:0]      count_reg, count_next;
    logic [cqd_pkg::CNT_W-1:0]      cap_reg;
    logic                           out_valid_reg;

    // response payload
    logic                           ok_reg, ok_next;
    logic [cqd_pkg::DATA_WIDTH-1:0] data_out_reg, data_out_next;
    logic [cqd_pkg::CNT_W-1:0]      occ_reg;

    logic                           in_accept;
    cqd_pkg::cell_cmd_t             cmd;
    logic [cqd_pkg::CNT_W-1:0]      count_m1;
    logic [cqd_pkg::CNT_W-1:0]      k_n;
    logic [cqd_pkg::CNT_W-1:0]      cap_clamped;

    logic [cqd_pkg::DATA_WIDTH-1:0] cell_data [cqd_pkg::DEPTH];

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;

    assign count_m1 = count_reg - 1'b1;
    // demote by n: clamp n to count-1
    assign k_n      = (move_count > count_m1) ? count_m1 : move_count;

    always_comb
    begin
        if (cfg_data == '0)
            cap_clamped = cqd_pkg::CNT_W'(1);
        else if (cfg_data > DEPTH_C)
            cap_clamped = DEPTH_C;
        else
            cap_clamped = cfg_data;
    end

    // command decode: one cell command per request, broadcast to the row
    always_comb
    begin
        ok_next       = 1'b0;
        data_out_next = '0;
        count_next    = count_reg;
        cmd.op        = cqd_pkg::CELL_HOLD;
        cmd.pos       = '0;
        case (kind)
            cqd_pkg::KIND_ENQUEUE:
            begin
                if (count_reg < cap_reg && count_reg < DEPTH_C)
                begin
                    ok_next    = 1'b1;
                    cmd.op     = cqd_pkg::CELL_LOAD;
                    cmd.pos    = count_reg[cqd_pkg::IDX_W-1:0];
                    count_next = count_reg + 1'b1;
                end
            end
            cqd_pkg::KIND_DEQUEUE:
            begin
                if (count_reg != '0)
                begin
                    ok_next       = 1'b1;
                    data_out_next = cell_data[0];
                    // shift everything up; old head lands past the new tail
                    cmd.op        = cqd_pkg::CELL_ROTATE;
                    cmd.pos       = count_m1[cqd_pkg::IDX_W-1:0];
                    count_next    = count_m1;
                end
            end
            cqd_pkg::KIND_PEEK:
            begin
                if (count_reg != '0)
                begin
                    ok_next       = 1'b1;
                    data_out_next = cell_data[0];
                end
            end
            cqd_pkg::KIND_EMPTY:
            begin
                ok_next = (count_reg == '0);
            end
            cqd_pkg::KIND_DEMOTE_H:
            begin
                if (count_reg >= cqd_pkg::CNT_W'(2))
                begin
                    ok_next = 1'b1;
                    cmd.op  = cqd_pkg::CELL_ROTATE;
                    cmd.pos = count_reg[cqd_pkg::IDX_W:1];
                end
            end
            cqd_pkg::KIND_DEMOTE_N:
            begin
                if (count_reg != '0)
                begin
                    ok_next = 1'b1;
                    cmd.op  = cqd_pkg::CELL_ROTATE;
                    cmd.pos = k_n[cqd_pkg::IDX_W-1:0];
                end
            end
            default:
            begin
                ok_next = 1'b0;
            end
        endcase
        // nothing moves unless the request is taken
        if (!in_accept)
            cmd.op = cqd_pkg::CELL_HOLD;
    end

    // row of cells; the last cell has no right neighbor and keeps its own word
    for (genvar i = 0; i < cqd_pkg::DEPTH; i++)
    begin : g_cell
        logic [cqd_pkg::DATA_WIDTH-1:0] right_w;
        if (i == cqd_pkg::DEPTH - 1)
        begin : g_last
            assign right_w = cell_data[i];
        end
        else
        begin : g_mid
            assign right_w = cell_data[i+1];
        end

        cqd_cell u_cell (
            .clk        (clk),
            .idx        (cqd_pkg::IDX_W'(i)),
            .cmd        (cmd),
            .load_data  (data_in),
            .right_data (right_w),
            .head_data  (cell_data[0]),
            .data       (cell_data[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            cap_reg       <= DEPTH_C;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                cap_reg <= cap_clamped;
            if (in_accept)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // response payload, loaded when a request is taken
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            ok_reg       <= ok_next;
            data_out_reg <= data_out_next;
            occ_reg      <= count_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign ok        = ok_reg;
    assign data_out  = data_out_reg;
    assign occupancy = occ_reg;

    // count never passes the built depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("entry count above depth");

    // the response reports the count the request left behind
    a_occ_match: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> occ_reg == count_reg)
        else $error("occupancy does not match count");

    // a taken enqueue that succeeds grows the count by one
    a_enq_grow: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && kind == cqd_pkg::KIND_ENQUEUE && ok_next
        |=> count_reg == $past(count_reg) + 1'b1)
        else $error("enqueue did not grow count");

    // dequeue on an empty queue is refused with zero data
    a_deq_empty: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && kind == cqd_pkg::KIND_DEQUEUE && count_reg == '0
        |=> out_valid && !ok_reg && data_out_reg == '0)
        else $error("dequeue from empty not refused");

endmodule

[bench/tb_circular_queue_with_demotion.sv]
// Self-checking testbench for the FIFO queue with head demotion.
module tb_circular_queue_with_demotion;
    timeunit 1ns;
    timeprecision 1ps;

    // Sizes and command codes taken from the package.
    localparam int DEPTH      = cqd_pkg::DEPTH;
    localparam int DATA_WIDTH = cqd_pkg::DATA_WIDTH;
    localparam int CNT_W      = cqd_pkg::CNT_W;

    localparam logic [2:0] KIND_ENQUEUE  = cqd_pkg::KIND_ENQUEUE;
    localparam logic [2:0] KIND_DEQUEUE  = cqd_pkg::KIND_DEQUEUE;
    localparam logic [2:0] KIND_PEEK     = cqd_pkg::KIND_PEEK;
    localparam logic [2:0] KIND_EMPTY    = cqd_pkg::KIND_EMPTY;
    localparam logic [2:0] KIND_DEMOTE_H = cqd_pkg::KIND_DEMOTE_H;
    localparam logic [2:0] KIND_DEMOTE_N = cqd_pkg::KIND_DEMOTE_N;

    // Kinds the block must reject without touching its state.
    localparam logic [2:0] KIND_UNDEFINED_6 = 3'd6;
    localparam logic [2:0] KIND_UNDEFINED_7 = 3'd7;

    localparam int CYCLE_LIMIT     = 500000;
    localparam int HOLD_OFF_CYCLES = 150;   // long receiver stall, fills the block
    localparam int PHASES          = 14;
    localparam int PHASE_ITEMS     = 110;
    localparam int PRESSURE_PHASE  = 3;
    localparam int DIRECTED_ROWS   = 27;

    // Capacity written at the start of each random phase; 0, 31 and 17 probe the clamp.
    localparam logic [4:0] PHASE_CAPS [PHASES] =
        '{5'd16, 5'd0, 5'd31, 5'd5, 5'd1, 5'd17, 5'd2, 5'd16, 5'd9, 5'd3, 5'd16, 5'd12,
          5'd1, 5'd16};

    typedef struct packed {
        logic                  ok;
        logic [DATA_WIDTH-1:0] data;
        logic [CNT_W-1:0]      occupancy;
    } response_t;

    // One directed request; a capacity write may precede it, and the response is either
    // typed in (typed = 1) or left to the predictor.
    typedef struct packed {
        bit                    set_cap;
        logic [4:0]            cap;
        logic [2:0]            op;
        logic [DATA_WIDTH-1:0] word;
        logic [CNT_W-1:0]      n;
        bit                    typed;
        response_t             want;
    } directed_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [4:0]            cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [2:0]            kind;
    logic [DATA_WIDTH-1:0] data_in;
    logic [CNT_W-1:0]      move_count;
    logic                  out_valid;
    logic                  out_ready;
    logic                  ok;
    logic [DATA_WIDTH-1:0] data_out;
    logic [CNT_W-1:0]      occupancy;

    // Predictor state: held words in queue order, head at index zero. The cell layout
    // inside the block never shows at the ports, so order alone is modeled.
    logic [DATA_WIDTH-1:0] queue_words [DEPTH];
    int                    words_held;
    int                    capacity_limit;

    response_t awaited_responses [$];
    int        mismatches;
    int        gap_odds;       // sender idles before a request with odds 1/(gap_odds+1)
    bit        hold_output;    // one-shot request for the long receiver stall
    bit        calm;           // final stretch: nobody idles

    directed_row_t directed [DIRECTED_ROWS] = '{
        // empty queue: every read and demotion fails, empty test passes
        '{1'b0, 5'd0, KIND_EMPTY,    32'h0000_0000, 5'd0,  1'b1, '{1'b1, 32'h0, 5'd0}},
        '{1'b0, 5'd0, KIND_DEQUEUE,  32'hDEAD_BEEF, 5'd0,  1'b1, '{1'b0, 32'h0, 5'd0}},
        '{1'b0, 5'd0, KIND_PEEK,     32'h0000_0000, 5'd0,  1'b1, '{1'b0, 32'h0, 5'd0}},
        '{1'b0, 5'd0, KIND_DEMOTE_H, 32'h0000_0000, 5'd0,  1'b1, '{1'b0, 32'h0, 5'd0}},
        '{1'b0, 5'd0, KIND_DEMOTE_N, 32'h0000_0000, 5'd3,  1'b1, '{1'b0, 32'h0, 5'd0}},
        '{1'b0, 5'd0, KIND_UNDEFINED_6, 32'hFFFF_FFFF, 5'd16, 1'b1, '{1'b0, 32'h0, 5'd0}},
        // single entry: demote by n succeeds as a no-op, demote half is refused
        '{1'b0, 5'd0, KIND_ENQUEUE,  32'h0000_0000, 5'd0,  1'b1, '{1'b1, 32'h0, 5'd1}},
        '{1'b0, 5'd0, KIND_DEMOTE_N, 32'h0000_0000, 5'd0,  1'b1, '{1'b1, 32'h0, 5'd1}},
        '{1'b0, 5'd0, KIND_DEMOTE_H, 32'h0000_0000, 5'd0,  1'b1, '{1'b0, 32'h0, 5'd1}},
        '{1'b0, 5'd0, KIND_DEMOTE_N, 32'h0000_0000, 5'd16, 1'b1, '{1'b1, 32'h0, 5'd1}},
        // two entries: demote half swaps them
        '{1'b0, 5'd0, KIND_ENQUEUE,  32'hFFFF_FFFF, 5'd0,  1'b1, '{1'b1, 32'h0, 5'd2}},
        '{1'b0, 5'd0, KIND_PEEK,     32'h0000_0000, 5'd0,  1'b1, '{1'b1, 32'h0, 5'd2}},
        '{1'b0, 5'd0, KIND_DEMOTE_H, 32'h0000_0000, 5'd0,  1'b1, '{1'b1, 32'h0, 5'd2}},
        '{1'b0, 5'd0, KIND_PEEK,     32'h0000_0000, 5'd0,  1'b1,
          '{1'b1, 32'hFFFF_FFFF, 5'd2}},
        // deeper reorder, n clamped to count-1
        '{1'b0, 5'd0, KIND_ENQUEUE,  32'hA5A5_5A5A, 5'd0,  1'b0, '0},
        '{1'b0, 5'd0, KIND_ENQUEUE,  32'h1234_5678, 5'd0,  1'b0, '0},
        '{1'b0, 5'd0, KIND_DEMOTE_N, 32'h0000_0000, 5'd16, 1'b0, '0},
        '{1'b0, 5'd0, KIND_UNDEFINED_7, 32'h0000_0000, 5'd0, 1'b1, '{1'b0, 32'h0, 5'd4}},
        '{1'b0, 5'd0, KIND_EMPTY,    32'h0000_0000, 5'd0,  1'b1, '{1'b0, 32'h0, 5'd4}},
        '{1'b0, 5'd0, KIND_DEQUEUE,  32'h0000_0000, 5'd0,  1'b0, '0},
        '{1'b0, 5'd0, KIND_DEQUEUE,  32'h0000_0000, 5'd0,  1'b0, '0},
        '{1'b0, 5'd0, KIND_DEQUEUE,  32'h0000_0000, 5'd0,  1'b0, '0},
        '{1'b0, 5'd0, KIND_DEQUEUE,  32'h0000_0000, 5'd0,  1'b0, '0},
        // capacity write of zero reads as one: second enqueue is refused
        '{1'b1, 5'd0, KIND_ENQUEUE,  32'h8000_0001, 5'd0,  1'b1, '{1'b1, 32'h0, 5'd1}},
        '{1'b0, 5'd0, KIND_ENQUEUE,  32'h7FFF_FFFE, 5'd0,  1'b1, '{1'b0, 32'h0, 5'd1}},
        '{1'b0, 5'd0, KIND_DEQUEUE,  32'h0000_0000, 5'd0,  1'b1,
          '{1'b1, 32'h8000_0001, 5'd0}},
        // capacity write of 31 reads as DEPTH
        '{1'b1, 5'd31, KIND_EMPTY,   32'h0000_0000, 5'd0,  1'b1, '{1'b1, 32'h0, 5'd0}}
    };

    circular_queue_with_demotion DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .data_in    (data_in),
        .move_count (move_count),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .ok         (ok),
        .data_out   (data_out),
        .occupancy  (occupancy)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Applies one command to the predictor state and returns the response it yields.
    // Both demotions rotate the first (k+1) words left by one: the head lands at slot k.
    function automatic response_t apply_command(input logic [2:0] op,
                                                input logic [DATA_WIDTH-1:0] word,
                                                input logic [CNT_W-1:0] n);
        response_t             r;
        int                    sink;
        int                    i;
        logic [DATA_WIDTH-1:0] head_word;
        r    = '0;
        sink = -1;
        case (op)
            KIND_ENQUEUE:
                if (words_held < capacity_limit)
                begin
                    queue_words[words_held] = word;
                    words_held++;
                    r.ok = 1'b1;
                end
            KIND_DEQUEUE:
                if (words_held > 0)
                begin
                    r.ok   = 1'b1;
                    r.data = queue_words[0];
                    for (i = 0; i < words_held - 1; i++)
                        queue_words[i] = queue_words[i + 1];
                    words_held--;
                end
            KIND_PEEK:
                if (words_held > 0)
                begin
                    r.ok   = 1'b1;
                    r.data = queue_words[0];
                end
            KIND_EMPTY:
                r.ok = (words_held == 0);
            KIND_DEMOTE_H:
                if (words_held >= 2)
                begin
                    r.ok = 1'b1;
                    sink = words_held / 2;
                end
            KIND_DEMOTE_N:
                if (words_held >= 1)
                begin
                    r.ok = 1'b1;
                    sink = (int'(n) > words_held - 1) ? words_held - 1 : int'(n);
                end
            default:
                ;
        endcase
        if (sink > 0)
        begin
            head_word = queue_words[0];
            for (i = 0; i < sink; i++)
                queue_words[i] = queue_words[i + 1];
            queue_words[sink] = head_word;
        end
        r.occupancy = CNT_W'(words_held);
        return r;
    endfunction

    // Writes the capacity register once the block has answered every request.
    // Lowering in_valid here keeps a stale request from being taken meanwhile.
    task automatic write_capacity(input logic [4:0] value);
        in_valid <= 1'b0;
        while (awaited_responses.size() != 0)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (value == 5'd0)
            capacity_limit = 1;
        else if (int'(value) > DEPTH)
            capacity_limit = DEPTH;
        else
            capacity_limit = int'(value);
    endtask

    // Offers one request, optionally after an idle burst, and returns the predicted
    // response at the edge where the block takes it.
    task automatic issue_command(input logic [2:0] op, input logic [DATA_WIDTH-1:0] word,
                                 input logic [CNT_W-1:0] n, output response_t predicted);
        if (!calm && gap_odds != 0 && $urandom_range(0, gap_odds) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        kind       <= op;
        data_in    <= word;
        move_count <= n;
        do
            @(posedge clk);
        while (!in_ready);
        predicted = apply_command(op, word, n);
    endtask

    // Sender: reset, directed table, then random phases, then drain and verdict.
    initial
    begin
        int                    row;
        int                    phase;
        int                    item;
        int                    enq_pct;
        int                    deq_pct;
        int                    roll;
        logic [2:0]            op;
        logic [DATA_WIDTH-1:0] word;
        logic [CNT_W-1:0]      n;
        response_t             predicted;

        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        in_valid    = 1'b0;
        kind        = KIND_ENQUEUE;
        data_in     = '0;
        move_count  = '0;
        hold_output = 1'b0;
        calm        = 1'b0;
        mismatches  = 0;
        gap_odds    = 2;
        words_held     = 0;
        capacity_limit = DEPTH;
        foreach (queue_words[i])
            queue_words[i] = '0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (row = 0; row < DIRECTED_ROWS; row++)
        begin
            if (directed[row].set_cap)
                write_capacity(directed[row].cap);
            issue_command(directed[row].op, directed[row].word, directed[row].n, predicted);
            awaited_responses.push_back(directed[row].typed ? directed[row].want : predicted);
        end

        // Random phases alternate between filling, churning and draining so that the
        // occupancy sweeps the whole range of each capacity, including counts left
        // above a freshly lowered capacity.
        for (phase = 0; phase < PHASES; phase++)
        begin
            write_capacity(PHASE_CAPS[phase]);
            calm = (phase == PHASES - 1);
            case (phase % 4)
                0: gap_odds = 0;
                1: gap_odds = 3;
                2: gap_odds = 8;
                default: gap_odds = 1;
            endcase
            case (phase % 3)
                0: begin enq_pct = 55; deq_pct = 15; end
                1: begin enq_pct = 30; deq_pct = 28; end
                default: begin enq_pct = 15; deq_pct = 55; end
            endcase
            for (item = 0; item < PHASE_ITEMS; item++)
            begin
                if (phase == PRESSURE_PHASE && item == 10)
                    hold_output = 1'b1;
                roll = $urandom_range(0, 99);
                if (roll < 2)
                    op = roll[0] ? KIND_UNDEFINED_7 : KIND_UNDEFINED_6;
                else if (roll < 2 + enq_pct)
                    op = KIND_ENQUEUE;
                else if (roll < 2 + enq_pct + deq_pct)
                    op = KIND_DEQUEUE;
                else
                    case ($urandom_range(0, 5))
                        0: op = KIND_PEEK;
                        1: op = KIND_EMPTY;
                        2, 3: op = KIND_DEMOTE_H;
                        default: op = KIND_DEMOTE_N;
                    endcase
                case ($urandom_range(0, 9))
                    0: word = '0;
                    1: word = '1;
                    default: word = $urandom;
                endcase
                if ($urandom_range(0, 3) == 0)
                    n = $urandom_range(0, 1) ? CNT_W'(DEPTH) : '0;
                else
                    n = CNT_W'($urandom_range(0, DEPTH));
                issue_command(op, word, n, predicted);
                awaited_responses.push_back(predicted);
            end
        end

        in_valid <= 1'b0;
        while (awaited_responses.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Receiver: mostly ready, with random stall bursts and one long hold-off that
    // lets the response register back up into the request side.
    initial
    begin
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_output)
            begin
                hold_output = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge clk);
            end
        end
    end

    // Response check: each taken response against the oldest prediction.
    always @(posedge clk)
    begin
        response_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (awaited_responses.size() == 0)
            begin
                $error("response with no request outstanding");
                mismatches++;
            end
            else
            begin
                want = awaited_responses.pop_front();
                if (ok !== want.ok)
                begin
                    $error("ok: expected %0d, got %0d", want.ok, ok);
                    mismatches++;
                end
                if (data_out !== want.data)
                begin
                    $error("data_out: expected 0x%08h, got 0x%08h", want.data, data_out);
                    mismatches++;
                end
                if (occupancy !== want.occupancy)
                begin
                    $error("occupancy: expected %0d, got %0d", want.occupancy, occupancy);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog.
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $error("timeout after %0d cycles", CYCLE_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
